FILE: src/wwkb_pkg.sv
// Package for the whole-word keyword blocker: shared types, register codes
// and byte classification helpers.
// No dependencies.
package wwkb_pkg;

  // Default sizes of the keyword set.
  localparam int KEYWORD_COUNT_DEF = 4;
  localparam int KEYWORD_BYTES_DEF = 8;

  // Configuration register map.
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int REG_ENABLE     = 0;
  localparam int REG_KEYWORD0   = 1;
  localparam int KEYWORD_REGS   = 4;

  // Byte counter saturates at its all-ones value.
  localparam int SEEN_W         = 4;
  localparam int HIT_W          = 2;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH    = 2;

  // Byte that joins words like a letter does.
  localparam logic [7:0] WORD_JOINER = 8'h5F;

  // One classified text byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] text;
    logic       boundary;
    logic       last;
  } wwkb_word_t;

  // ASCII lower-casing: only upper-case letters change.
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // A boundary byte is neither a letter, a digit nor the word joiner.
  function automatic logic is_boundary(input logic [7:0] b);
    logic alnum;
    alnum = b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]};
    return !alnum && (b != WORD_JOINER);
  endfunction

  // Number of leading non-zero bytes, looking at no more than nbytes.
  function automatic logic [3:0] kw_length(input logic [CFG_DATA_W-1:0] kw,
                                           input int nbytes);
    logic [3:0] n;
    logic       stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && (i < nbytes) && (kw[8*i +: 8] != 8'h00)) begin
        n = n + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

FILE: src/wwkb_if.sv
// Handshake channels of the whole-word keyword blocker: text input,
// verdict output and configuration write. Depends on wwkb_pkg.

// Text bytes, one word per handshake.
interface wwkb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

// One verdict word per command.
interface wwkb_out_if;
  logic                       valid;
  logic                       ready;
  logic                       allowed;
  logic [wwkb_pkg::HIT_W-1:0] hit_number;

  modport source (output valid, output allowed, output hit_number, input ready);
  modport sink   (input valid, input allowed, input hit_number, output ready);
endinterface

// Register writes.
interface wwkb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wwkb_pkg::CFG_INDEX_W-1:0] reg_index;
  logic [wwkb_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: src/wwkb_cfg.sv
// Configuration registers of the keyword blocker: enable bit, keyword bytes
// and precomputed keyword lengths. Depends on wwkb_pkg and wwkb_if.
module wwkb_cfg #(
  parameter int KEYWORD_COUNT = wwkb_pkg::KEYWORD_COUNT_DEF,
  parameter int KEYWORD_BYTES = wwkb_pkg::KEYWORD_BYTES_DEF,
  localparam int LEN_W        = $clog2(KEYWORD_BYTES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wwkb_cfg_if.sink                     cfg_if,
  output logic                         check_enable,
  output logic [KEYWORD_BYTES*8-1:0]   keywords [KEYWORD_COUNT],
  output logic [LEN_W-1:0]             kw_lengths [KEYWORD_COUNT]
);

  logic                       enable_r;
  logic [KEYWORD_BYTES*8-1:0] kw_r  [KEYWORD_COUNT];
  logic [LEN_W-1:0]           len_r [KEYWORD_COUNT];
  logic                       wr_en;

  // Writes are always taken.
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;

  // Register file; keywords beyond the mapped registers stay empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        kw_r[k]  <= '0;
        len_r[k] <= '0;
      end
    end else if (wr_en) begin
      if (cfg_if.reg_index == wwkb_pkg::CFG_INDEX_W'(wwkb_pkg::REG_ENABLE)) begin
        enable_r <= cfg_if.wdata[0];
      end
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        if ((k < wwkb_pkg::KEYWORD_REGS) &&
            (cfg_if.reg_index == wwkb_pkg::CFG_INDEX_W'(wwkb_pkg::REG_KEYWORD0 + k))) begin
          kw_r[k]  <= cfg_if.wdata[KEYWORD_BYTES*8-1:0];
          len_r[k] <= LEN_W'(wwkb_pkg::kw_length(cfg_if.wdata, KEYWORD_BYTES));
        end
      end
    end
  end

  assign check_enable = enable_r;
  assign keywords     = kw_r;
  assign kw_lengths   = len_r;

endmodule

FILE: src/wwkb_front.sv
// Front end of the keyword blocker: accepts text bytes, lower-cases and
// classifies them, and pushes them into the queue. Depends on wwkb_pkg, wwkb_if.
module wwkb_front (
  wwkb_in_if.sink              in_if,
  input  logic                 queue_full,
  output logic                 push,
  output wwkb_pkg::wwkb_word_t push_word
);

  // Accept whenever the queue has room.
  assign in_if.ready = !queue_full;
  assign push        = in_if.valid && !queue_full;

  // Classify the byte; lower-casing keeps the boundary class unchanged.
  always_comb begin
    push_word.text     = wwkb_pkg::to_lower(in_if.text_byte);
    push_word.boundary = wwkb_pkg::is_boundary(in_if.text_byte);
    push_word.last     = in_if.final_byte;
  end

endmodule

FILE: src/wwkb_queue.sv
// Short queue that decouples the front and back of the keyword blocker.
// Depends on wwkb_pkg.
module wwkb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  wwkb_pkg::wwkb_word_t push_word,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output wwkb_pkg::wwkb_word_t head_word
);

  localparam int DEPTH = wwkb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  wwkb_pkg::wwkb_word_t slot_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_word = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots carry payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

FILE: src/wwkb_back.sv
// Back end of the keyword blocker: history window, whole-word matching
// against all keywords in parallel, and the verdict register.
// Depends on wwkb_pkg and wwkb_if.
module wwkb_back #(
  parameter int KEYWORD_COUNT = wwkb_pkg::KEYWORD_COUNT_DEF,
  parameter int KEYWORD_BYTES = wwkb_pkg::KEYWORD_BYTES_DEF,
  localparam int LEN_W        = $clog2(KEYWORD_BYTES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       word_avail,
  input  wwkb_pkg::wwkb_word_t       word,
  output logic                       pop,
  input  logic                       check_enable,
  input  logic [KEYWORD_BYTES*8-1:0] keywords [KEYWORD_COUNT],
  input  logic [LEN_W-1:0]           kw_lengths [KEYWORD_COUNT],
  wwkb_out_if.source                 out_if
);

  localparam int HIST = KEYWORD_BYTES + 1;
  localparam int SW   = wwkb_pkg::SEEN_W;

  // Per-command state.
  logic [7:0]                 hist_r [HIST];
  logic [HIST-1:0]            bnd_r;
  logic [SW-1:0]              seen_r, seen_nxt;
  logic [KEYWORD_COUNT-1:0]   pending_r, pending_nxt;
  logic [KEYWORD_COUNT-1:0]   hits_r, hits_nxt;

  // Verdict register.
  logic                       out_valid_r, out_valid_nxt;
  logic                       allowed_r, allowed_nxt;
  logic [wwkb_pkg::HIT_W-1:0] hit_r, hit_nxt;

  logic [7:0]                 hist_n [HIST];
  logic [HIST-1:0]            bnd_n;
  logic [SW-1:0]              seen_n;
  logic [KEYWORD_COUNT-1:0]   hits_mid;
  logic [KEYWORD_COUNT-1:0]   now;
  logic [KEYWORD_COUNT-1:0]   hits_fin;
  logic                       out_free;

  // A final word needs the verdict register free; other words never wait.
  assign out_free = !out_valid_r || out_if.ready;
  assign pop      = word_avail && (!word.last || out_free);

  // Window as it stands once the new byte is shifted in.
  always_comb begin
    hist_n[0] = word.text;
    bnd_n[0]  = word.boundary;
    for (int j = 1; j < HIST; j++) begin
      hist_n[j] = hist_r[j-1];
      bnd_n[j]  = bnd_r[j-1];
    end
    seen_n = (seen_r == {SW{1'b1}}) ? seen_r : seen_r + 1'b1;
  end

  // Match of every keyword ending at the newest byte with a clean left side.
  always_comb begin
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] idx;
    logic             ok;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      len = kw_lengths[k];
      ok  = (len != '0) && (seen_n >= SW'(len));
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
        idx = len - 1'b1 - LEN_W'(i);
        if ((LEN_W'(i) < len) && (hist_n[idx] != keywords[k][8*i +: 8])) begin
          ok = 1'b0;
        end
      end
      now[k] = ok && ((seen_n == SW'(len)) || bnd_n[len]);
    end
  end

  // Right side of a pending match closes on a boundary byte.
  assign hits_mid = hits_r | (word.boundary ? pending_r : '0);
  assign hits_fin = hits_mid | now;

  // Next state of the per-command registers.
  always_comb begin
    seen_nxt    = seen_r;
    pending_nxt = pending_r;
    hits_nxt    = hits_r;
    if (pop) begin
      if (word.last) begin
        seen_nxt    = '0;
        pending_nxt = '0;
        hits_nxt    = '0;
      end else begin
        seen_nxt    = seen_n;
        pending_nxt = now;
        hits_nxt    = hits_mid;
      end
    end
  end

  // Verdict: lowest-numbered keyword that hit, when checking is on.
  always_comb begin
    out_valid_nxt = out_valid_r;
    allowed_nxt   = allowed_r;
    hit_nxt       = hit_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && word.last) begin
      out_valid_nxt = 1'b1;
      allowed_nxt   = !(check_enable && (hits_fin != '0));
      hit_nxt       = '0;
      if (check_enable) begin
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
          if (hits_fin[k]) begin
            hit_nxt = wwkb_pkg::HIT_W'(k);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      pending_r   <= '0;
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      pending_r   <= pending_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Window and verdict payload; the byte count gates stale window bytes.
  always_ff @(posedge clk) begin
    if (pop) begin
      hist_r <= hist_n;
      bnd_r  <= bnd_n;
    end
    allowed_r <= allowed_nxt;
    hit_r     <= hit_nxt;
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.allowed    = allowed_r;
  assign out_if.hit_number = hit_r;

endmodule

FILE: src/whole_word_keyword_blocker.sv
// Top level of the whole-word keyword blocker.
// Depends on wwkb_pkg, wwkb_if, wwkb_cfg, wwkb_front, wwkb_queue, wwkb_back.
//
// The block takes one command byte per clock while the queue has room, with
// the last byte marked, and returns one verdict word per command: allowed, or
// blocked with the lowest keyword number that matched as a whole word. Text is
// lower-cased before the compare, keywords are not. Bytes stream at one per
// cycle unless a final byte waits; that figure is set by the back end, which
// shifts the history window and checks every keyword against it in parallel.
// The verdict register loads as the final byte leaves the queue, and a two-word
// queue between front and back keeps bytes flowing while a verdict waits. The
// user must write keyword and enable registers through the configuration port
// only while no command is in flight; the block itself does not enforce this.
module whole_word_keyword_blocker #(
  parameter int KEYWORD_COUNT = wwkb_pkg::KEYWORD_COUNT_DEF,
  parameter int KEYWORD_BYTES = wwkb_pkg::KEYWORD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wwkb_in_if.sink    in_if,
  wwkb_out_if.source out_if,
  wwkb_cfg_if.sink   cfg_if
);

  localparam int LEN_W = $clog2(KEYWORD_BYTES + 1);

  logic                       check_enable;
  logic [KEYWORD_BYTES*8-1:0] keywords   [KEYWORD_COUNT];
  logic [LEN_W-1:0]           kw_lengths [KEYWORD_COUNT];

  logic                       push;
  wwkb_pkg::wwkb_word_t       push_word;
  logic                       pop;
  logic                       queue_full;
  logic                       queue_not_empty;
  wwkb_pkg::wwkb_word_t       head_word;

  // Register file.
  wwkb_cfg #(
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_if       (cfg_if),
    .check_enable (check_enable),
    .keywords     (keywords),
    .kw_lengths   (kw_lengths)
  );

  // Byte intake and classification.
  wwkb_front u_front (
    .in_if      (in_if),
    .queue_full (queue_full),
    .push       (push),
    .push_word  (push_word)
  );

  // Decoupling queue.
  wwkb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_word (head_word)
  );

  // Matching and verdict.
  wwkb_back #(
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .KEYWORD_BYTES (KEYWORD_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .word_avail   (queue_not_empty),
    .word         (head_word),
    .pop          (pop),
    .check_enable (check_enable),
    .keywords     (keywords),
    .kw_lengths   (kw_lengths),
    .out_if       (out_if)
  );

endmodule

FILE: src/wwkb_checker.sv
// Port-level checker for the whole-word keyword blocker, and the bind that
// attaches it to the top level. Depends on wwkb_pkg.
module wwkb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_final,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_allowed,
  input logic [wwkb_pkg::HIT_W-1:0]       out_hit,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [wwkb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [wwkb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic [2:0] open_r;
  logic       enable_r;
  logic       fin_acc;
  logic       out_acc;

  assign fin_acc = in_valid && in_ready && in_final;
  assign out_acc = out_valid && out_ready;

  // Commands whose final word went in but whose verdict is not yet out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else if (fin_acc && !out_acc) begin
      open_r <= open_r + 3'd1;
    end else if (out_acc && !fin_acc) begin
      open_r <= open_r - 3'd1;
    end
  end

  // Shadow of the enable register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index == wwkb_pkg::CFG_INDEX_W'(wwkb_pkg::REG_ENABLE))) begin
      enable_r <= cfg_data[0];
    end
  end

  // A stalled verdict holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_allowed) && $stable(out_hit))
    else $error("verdict changed while stalled");

  // Every verdict belongs to a command that was finished.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 3'd0)
    else $error("verdict without a finished command");

  // Queue and verdict register bound the commands in flight.
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= 3'd3)
    else $error("too many commands in flight");

  // With checking off, every command passes.
  a_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !enable_r |-> out_allowed)
    else $error("command blocked while checking is off");

  // A passing command reports keyword zero.
  a_allowed_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_allowed |-> out_hit == '0)
    else $error("keyword number on a passing command");

endmodule

bind whole_word_keyword_blocker wwkb_checker u_wwkb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .in_final    (in_if.final_byte),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_allowed (out_if.allowed),
  .out_hit     (out_if.hit_number),
  .cfg_valid   (cfg_if.valid),
  .cfg_ready   (cfg_if.ready),
  .cfg_index   (cfg_if.reg_index),
  .cfg_data    (cfg_if.wdata)
);
